// File: rtl/bgpasp_pkg.sv
// Package with the parse phases, attribute codes and phase helpers of the AS_PATH parser.
`default_nettype none

package bgpasp_pkg;

  localparam logic [7:0] ATTR_FLAG_EXTLEN    = 8'h10;
  localparam logic [7:0] ATTR_AS_PATH        = 8'd2;
  localparam logic [7:0] SEG_AS_SET          = 8'd1;
  localparam logic [7:0] SEG_AS_SEQUENCE     = 8'd2;
  localparam logic [7:0] SEG_CONFED_SEQUENCE = 8'd3;
  localparam logic [7:0] SEG_CONFED_SET      = 8'd4;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_LEN_LO,
    PH_FLAG,
    PH_TYPE,
    PH_ALEN_HI,
    PH_ALEN_LO,
    PH_SKIP,
    PH_SEG_TYPE,
    PH_SEG_COUNT,
    PH_SEG_NUM,
    PH_DONE
  } phase_t;

  // A further attribute needs at least a flag, a type and a length byte.
  function automatic phase_t next_attr_phase(input logic [15:0] blk);
    next_attr_phase = (blk >= 16'd3) ? PH_FLAG : PH_DONE;
  endfunction

  function automatic phase_t skip_rest_phase(input logic [15:0] vr, input logic [15:0] blk);
    skip_rest_phase = (vr == 16'd0) ? next_attr_phase(blk) : PH_SKIP;
  endfunction

  function automatic phase_t next_seg_phase(input logic [15:0] vr, input logic [15:0] blk);
    if (vr == 16'd0) begin
      next_seg_phase = next_attr_phase(blk);
    end else if (vr < 16'd2) begin
      next_seg_phase = PH_SKIP;
    end else begin
      next_seg_phase = PH_SEG_TYPE;
    end
  endfunction

endpackage

`default_nettype wire

// File: rtl/bgp_as_path_attribute_parser.sv
// Top level of the AS_PATH parser: byte parser, path store memory and result read-out.
`default_nettype none

// Channel   Beat                                                   Handshake
// byte      data_byte, first_of_record, end_of_record, as_four_bytes  byte_valid / byte_stall
// result    path_found, as_number, path_index, path_length, last   result_valid / result_stall
//
// Each byte beat is parsed as it is accepted, so bytes stream at one per cycle while byte_stall is low.
// After an end byte with N stored AS numbers, N result beats leave at one per cycle from
// the store's read port while result_stall is low; bytes stall until the read-out ends.
// An empty path gives one not-found beat on the next cycle. An end byte also stalls
// while a result beat is held by result_stall.
// Reset clears parser and read-out state; the path store is read only where written.
module bgp_as_path_attribute_parser
  import bgpasp_pkg::*;
#(
  parameter int PATH_DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        byte_valid,
  output logic             byte_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        first_of_record,
  input  wire logic        end_of_record,
  input  wire logic        as_four_bytes,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic             path_found,
  output logic [31:0]      as_number,
  output logic [4:0]       path_index,
  output logic [4:0]       path_length,
  output logic             last
);

  localparam int AW = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;

  phase_t          phase, phase_next;
  logic [15:0]     block_remaining, block_remaining_next;
  logic [15:0]     value_remaining, value_remaining_next;
  logic [7:0]      segment_remaining, segment_remaining_next;
  logic [7:0]      attribute_kind, attribute_kind_next;
  logic            extended_length, extended_length_next;
  logic [7:0]      segment_kind, segment_kind_next;
  logic [1:0]      byte_in_number, byte_in_number_next;
  logic [31:0]     number_accumulator, number_accumulator_next;
  logic            wide_numbers, wide_numbers_next;
  logic [AW-1:0]   path_count, path_count_next;
  logic [AW-1:0]   pending_count, pending_count_next;

  logic [31:0]     path_store [PATH_DEPTH];
  logic            store_we;
  logic [AW-1:0]   store_addr;
  logic [31:0]     store_wdata;

  logic            draining;
  logic [AW-1:0]   rd_idx;
  logic            s1_valid;
  logic [AW-1:0]   s1_idx;
  logic [31:0]     rd_data;
  logic            issue;
  logic            out_free;
  logic [AW-1:0]   last_idx;
  logic [6:0]      idx_ext;
  logic [6:0]      len_ext;

  logic            byte_acc;
  logic            rec_end;
  logic            found;
  logic [15:0]     br_type;
  logic [15:0]     br_len;
  logic [15:0]     alen_val;
  logic [15:0]     br_value;
  logic            overrun;
  logic [15:0]     vr_dec;
  logic [9:0]      seg_bytes;
  logic            too_big;
  logic            confed;
  logic            known;
  logic [8:0]      pc_sum;
  logic            overflow;
  logic            count_ok;
  logic            num_done;
  logic [AW-1:0]   pending_after;
  logic [AW-1:0]   commit_sum;
  logic [7:0]      seg_rem_dec;

  assign byte_acc   = byte_valid && !byte_stall;
  assign out_free   = !result_valid || !result_stall;
  assign byte_stall = draining || s1_valid || (result_valid && result_stall && end_of_record);

  assign br_type    = block_remaining - 16'd2;
  assign br_len     = block_remaining - 16'd1;
  assign alen_val   = {extended_length ? value_remaining[15:8] : 8'h00, data_byte};
  assign br_value   = br_len - alen_val;
  assign overrun    = br_len < alen_val;
  assign vr_dec     = value_remaining - 16'd1;
  assign seg_bytes  = wide_numbers ? {data_byte, 2'b00} : {1'b0, data_byte, 1'b0};
  assign too_big    = {6'd0, seg_bytes} > vr_dec;
  assign confed     = (segment_kind == SEG_CONFED_SEQUENCE) || (segment_kind == SEG_CONFED_SET);
  assign known      = (segment_kind == SEG_AS_SET) || (segment_kind == SEG_AS_SEQUENCE);
  assign pc_sum     = 9'(path_count) + {1'b0, data_byte};
  assign overflow   = pc_sum >= 9'(PATH_DEPTH);
  assign count_ok   = !too_big && (confed || (known && !overflow));
  assign num_done   = byte_in_number == (wide_numbers ? 2'd3 : 2'd1);
  assign pending_after = confed ? pending_count : pending_count + AW'(1);
  assign commit_sum = path_count + pending_after;
  assign seg_rem_dec = segment_remaining - 8'd1;

  assign store_addr  = path_count + pending_count;
  assign store_wdata = {number_accumulator[23:0], data_byte};

  assign rec_end = byte_acc && end_of_record && (first_of_record || phase != PH_IDLE);
  assign found   = path_count_next != '0;

  always_comb begin
    phase_next = phase;
    if (byte_acc) begin
      if (first_of_record) begin
        phase_next = PH_LEN_LO;
      end else begin
        case (phase)
          PH_LEN_LO: begin
            phase_next = next_attr_phase(block_remaining | {8'h00, data_byte});
          end
          PH_FLAG: begin
            phase_next = PH_TYPE;
          end
          PH_TYPE: begin
            if (extended_length) begin
              phase_next = (br_type < 16'd2) ? PH_DONE : PH_ALEN_HI;
            end else begin
              phase_next = PH_ALEN_LO;
            end
          end
          PH_ALEN_HI: begin
            phase_next = PH_ALEN_LO;
          end
          PH_ALEN_LO: begin
            if (overrun) begin
              phase_next = PH_DONE;
            end else if (attribute_kind == ATTR_AS_PATH) begin
              phase_next = next_seg_phase(alen_val, br_value);
            end else begin
              phase_next = skip_rest_phase(alen_val, br_value);
            end
          end
          PH_SKIP: begin
            phase_next = (vr_dec == 16'd0) ? next_attr_phase(block_remaining) : PH_SKIP;
          end
          PH_SEG_TYPE: begin
            phase_next = PH_SEG_COUNT;
          end
          PH_SEG_COUNT: begin
            if (!count_ok) begin
              phase_next = skip_rest_phase(vr_dec, block_remaining);
            end else if (data_byte == 8'd0) begin
              phase_next = next_seg_phase(vr_dec, block_remaining);
            end else begin
              phase_next = PH_SEG_NUM;
            end
          end
          PH_SEG_NUM: begin
            if (num_done && seg_rem_dec == 8'd0) begin
              phase_next = next_seg_phase(vr_dec, block_remaining);
            end
          end
          default: begin
            phase_next = phase;
          end
        endcase
      end
      if (end_of_record) begin
        phase_next = PH_IDLE;
      end
    end
  end

  always_comb begin
    block_remaining_next    = block_remaining;
    value_remaining_next    = value_remaining;
    segment_remaining_next  = segment_remaining;
    attribute_kind_next     = attribute_kind;
    extended_length_next    = extended_length;
    segment_kind_next       = segment_kind;
    byte_in_number_next     = byte_in_number;
    number_accumulator_next = number_accumulator;
    wide_numbers_next       = wide_numbers;
    path_count_next         = path_count;
    pending_count_next      = pending_count;
    store_we                = 1'b0;
    if (byte_acc) begin
      if (first_of_record) begin
        block_remaining_next    = {data_byte, 8'h00};
        value_remaining_next    = '0;
        segment_remaining_next  = '0;
        attribute_kind_next     = '0;
        extended_length_next    = 1'b0;
        segment_kind_next       = '0;
        byte_in_number_next     = '0;
        number_accumulator_next = '0;
        wide_numbers_next       = as_four_bytes;
        path_count_next         = '0;
        pending_count_next      = '0;
      end else begin
        case (phase)
          PH_LEN_LO: begin
            block_remaining_next = block_remaining | {8'h00, data_byte};
          end
          PH_FLAG: begin
            extended_length_next = (data_byte & ATTR_FLAG_EXTLEN) != 8'h00;
          end
          PH_TYPE: begin
            attribute_kind_next  = data_byte;
            block_remaining_next = br_type;
          end
          PH_ALEN_HI: begin
            value_remaining_next = {data_byte, 8'h00};
            block_remaining_next = br_len;
          end
          PH_ALEN_LO: begin
            value_remaining_next = alen_val;
            block_remaining_next = overrun ? br_len : br_value;
            if (!overrun && attribute_kind == ATTR_AS_PATH) begin
              path_count_next    = '0;
              pending_count_next = '0;
            end
          end
          PH_SKIP: begin
            value_remaining_next = vr_dec;
          end
          PH_SEG_TYPE: begin
            segment_kind_next    = data_byte;
            value_remaining_next = vr_dec;
          end
          PH_SEG_COUNT: begin
            value_remaining_next = vr_dec;
            if (count_ok && data_byte != 8'd0) begin
              segment_remaining_next  = data_byte;
              byte_in_number_next     = '0;
              number_accumulator_next = '0;
              pending_count_next      = '0;
            end
          end
          PH_SEG_NUM: begin
            value_remaining_next = vr_dec;
            if (num_done) begin
              store_we                = !confed;
              number_accumulator_next = '0;
              byte_in_number_next     = '0;
              segment_remaining_next  = seg_rem_dec;
              pending_count_next      = pending_after;
              if (seg_rem_dec == 8'd0) begin
                path_count_next    = commit_sum;
                pending_count_next = '0;
              end
            end else begin
              number_accumulator_next = store_wdata;
              byte_in_number_next     = byte_in_number + 2'd1;
            end
          end
          default: begin
            block_remaining_next = block_remaining;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_IDLE;
      block_remaining    <= '0;
      value_remaining    <= '0;
      segment_remaining  <= '0;
      attribute_kind     <= '0;
      extended_length    <= 1'b0;
      segment_kind       <= '0;
      byte_in_number     <= '0;
      number_accumulator <= '0;
      wide_numbers       <= 1'b0;
      path_count         <= '0;
      pending_count      <= '0;
    end else begin
      phase              <= phase_next;
      block_remaining    <= block_remaining_next;
      value_remaining    <= value_remaining_next;
      segment_remaining  <= segment_remaining_next;
      attribute_kind     <= attribute_kind_next;
      extended_length    <= extended_length_next;
      segment_kind       <= segment_kind_next;
      byte_in_number     <= byte_in_number_next;
      number_accumulator <= number_accumulator_next;
      wide_numbers       <= wide_numbers_next;
      path_count         <= path_count_next;
      pending_count      <= pending_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      path_store[store_addr] <= store_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= path_store[rd_idx];
    end
  end

  assign issue    = draining && (!s1_valid || out_free);
  assign last_idx = path_count - AW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      draining <= 1'b0;
      rd_idx   <= '0;
      s1_valid <= 1'b0;
      s1_idx   <= '0;
    end else begin
      if (rec_end && found) begin
        draining <= 1'b1;
        rd_idx   <= '0;
      end else if (issue) begin
        rd_idx <= rd_idx + AW'(1);
        if (rd_idx == last_idx) begin
          draining <= 1'b0;
        end
      end
      if (issue) begin
        s1_valid <= 1'b1;
        s1_idx   <= rd_idx;
      end else if (out_free) begin
        s1_valid <= 1'b0;
      end
    end
  end

  assign idx_ext = 7'(s1_idx);
  assign len_ext = 7'(path_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= s1_valid || (rec_end && !found);
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (s1_valid) begin
        path_found  <= 1'b1;
        as_number   <= rd_data;
        path_index  <= idx_ext[4:0];
        path_length <= len_ext[4:0];
        last        <= s1_idx == last_idx;
      end else if (rec_end && !found) begin
        path_found  <= 1'b0;
        as_number   <= '0;
        path_index  <= '0;
        path_length <= '0;
        last        <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_byte_while_draining: assert property (@(posedge clk) disable iff (rst)
    (draining || s1_valid) |-> !byte_acc)
    else $error("byte beat accepted during path read-out");

  a_no_write_while_draining: assert property (@(posedge clk) disable iff (rst)
    store_we |-> (!draining && !s1_valid))
    else $error("path store written during read-out");

  a_last_matches_length: assert property (@(posedge clk) disable iff (rst)
    (result_valid && path_found && last) |-> (path_index + 5'd1 == path_length))
    else $error("last beat does not close the path");

  a_not_found_beat: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !path_found) |-> (last && as_number == 32'd0 && path_length == 5'd0))
    else $error("malformed not-found beat");

  a_drain_starts_empty: assert property (@(posedge clk) disable iff (rst)
    $rose(draining) |-> (rd_idx == '0 && path_count != '0))
    else $error("read-out started with bad index or empty path");
`endif

endmodule

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the AS_PATH parser with directed and random records.
`timescale 1ns / 100ps

module testbench
  import bgpasp_pkg::*;
();

  localparam int AS_PATH_DEPTH = 32;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_BYTES = 90;
  localparam logic [7:0] ATTR_ORIGIN = 8'd1;
  localparam logic [7:0] SEG_UNKNOWN = 8'd9;
  localparam logic [7:0] FLAGS_SHORT = 8'h40;
  localparam logic [7:0] FLAGS_EXT = FLAGS_SHORT | ATTR_FLAG_EXTLEN;

  typedef struct packed {
    logic        found;
    logic [31:0] asn;
    logic [4:0]  idx;
    logic [4:0]  len;
    logic        final_beat;
  } as_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        first_of_record = 1'b0;
  logic        end_of_record = 1'b0;
  logic        as_four_bytes = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic        path_found;
  logic [31:0] as_number;
  logic [4:0]  path_index;
  logic [4:0]  path_length;
  logic        last;

  bgp_as_path_attribute_parser #(.PATH_DEPTH(AS_PATH_DEPTH)) dut (.*);

  phase_t      ph = PH_IDLE;
  logic [15:0] blk_left = '0;
  logic [15:0] val_left = '0;
  logic [7:0]  seg_left = '0;
  logic [7:0]  attr_kind = '0;
  logic [7:0]  seg_kind = '0;
  bit          ext_len;
  bit          wide_as;
  int          byte_pos;
  logic [31:0] acc = '0;
  int          path_cnt;
  int          pend_cnt;
  logic [31:0] as_store [AS_PATH_DEPTH];

  as_result_t  expected_as_q[$];
  logic [7:0]  value_bytes[$];
  logic [7:0]  block_bytes[$];
  logic [7:0]  record_bytes[$];

  bit no_idle;
  bit hold_req;
  bit hold_active;
  int idle_cycles;
  int error_count;
  int bytes_accepted;
  int records_sent;
  int record_bytes_sent;
  int results_checked;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void attr_follows();
    if (blk_left >= 16'd3) ph = PH_FLAG;
    else ph = PH_DONE;
  endfunction

  function automatic void skip_value();
    if (val_left == 16'd0) attr_follows();
    else ph = PH_SKIP;
  endfunction

  function automatic void segment_follows();
    if (val_left == 16'd0) attr_follows();
    else if (val_left < 16'd2) ph = PH_SKIP;
    else ph = PH_SEG_TYPE;
  endfunction

  function automatic void parse_as_path_byte(input logic [7:0] d);
    int width;
    bit confed;
    int slot;
    width = wide_as ? 4 : 2;
    confed = (seg_kind == SEG_CONFED_SEQUENCE) || (seg_kind == SEG_CONFED_SET);
    case (ph)
      PH_LEN_LO: begin
        blk_left = blk_left | {8'h00, d};
        attr_follows();
      end
      PH_FLAG: begin
        ext_len = (d & ATTR_FLAG_EXTLEN) != 8'h00;
        ph = PH_TYPE;
      end
      PH_TYPE: begin
        attr_kind = d;
        blk_left = blk_left - 16'd2;
        if (ext_len) begin
          if (blk_left < 16'd2) ph = PH_DONE;
          else ph = PH_ALEN_HI;
        end else begin
          ph = PH_ALEN_LO;
        end
      end
      PH_ALEN_HI: begin
        val_left = {d, 8'h00};
        blk_left = blk_left - 16'd1;
        ph = PH_ALEN_LO;
      end
      PH_ALEN_LO: begin
        if (ext_len) val_left = val_left | {8'h00, d};
        else val_left = {8'h00, d};
        blk_left = blk_left - 16'd1;
        if (blk_left < val_left) begin
          ph = PH_DONE;
        end else begin
          blk_left = blk_left - val_left;
          if (attr_kind == ATTR_AS_PATH) begin
            path_cnt = 0;
            pend_cnt = 0;
            segment_follows();
          end else begin
            skip_value();
          end
        end
      end
      PH_SKIP: begin
        val_left = val_left - 16'd1;
        if (val_left == 16'd0) attr_follows();
      end
      PH_SEG_TYPE: begin
        seg_kind = d;
        val_left = val_left - 16'd1;
        ph = PH_SEG_COUNT;
      end
      PH_SEG_COUNT: begin
        val_left = val_left - 16'd1;
        if (int'(d) * width > int'(val_left)) begin
          skip_value();
        end else if (!confed && seg_kind != SEG_AS_SET && seg_kind != SEG_AS_SEQUENCE) begin
          skip_value();
        end else if (!confed && path_cnt + int'(d) >= AS_PATH_DEPTH) begin
          skip_value();
        end else if (d == 8'd0) begin
          segment_follows();
        end else begin
          seg_left = d;
          byte_pos = 0;
          acc = '0;
          pend_cnt = 0;
          ph = PH_SEG_NUM;
        end
      end
      PH_SEG_NUM: begin
        val_left = val_left - 16'd1;
        acc = {acc[23:0], d};
        if (byte_pos + 1 >= width) begin
          if (!confed) begin
            slot = path_cnt + pend_cnt;
            if (slot < AS_PATH_DEPTH) as_store[slot] = acc;
            pend_cnt = pend_cnt + 1;
          end
          acc = '0;
          byte_pos = 0;
          seg_left = seg_left - 8'd1;
          if (seg_left == 8'd0) begin
            path_cnt = path_cnt + pend_cnt;
            pend_cnt = 0;
            segment_follows();
          end
        end else begin
          byte_pos = byte_pos + 1;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void predict_as_path(input logic [7:0] d, input logic f, input logic e,
                                          input logic w);
    as_result_t r;
    int i;
    if (f) begin
      ph = PH_LEN_LO;
      blk_left = {d, 8'h00};
      val_left = '0;
      seg_left = '0;
      attr_kind = '0;
      seg_kind = '0;
      ext_len = 1'b0;
      byte_pos = 0;
      acc = '0;
      wide_as = w;
      path_cnt = 0;
      pend_cnt = 0;
    end else if (ph == PH_IDLE) begin
      return;
    end else begin
      parse_as_path_byte(d);
    end
    if (!e) return;
    ph = PH_IDLE;
    if (path_cnt == 0) begin
      r = '0;
      r.final_beat = 1'b1;
      expected_as_q.push_back(r);
    end else begin
      for (i = 0; i < path_cnt; i++) begin
        r.found = 1'b1;
        r.asn = as_store[i];
        r.idx = i[4:0];
        r.len = path_cnt[4:0];
        r.final_beat = (i + 1 == path_cnt);
        expected_as_q.push_back(r);
      end
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Bytes are predicted and results checked in the same process, so a result beat that
  // leaves in the cycle of its byte beat is never seen ahead of its expectation.
  always @(posedge clk) begin
    as_result_t want;
    bit byte_beat;
    bit result_beat;
    byte_beat = !rst && byte_valid && !byte_stall;
    result_beat = !rst && result_valid && !result_stall;
    if (byte_beat) begin
      predict_as_path(data_byte, first_of_record, end_of_record, as_four_bytes);
      bytes_accepted++;
    end
    if (result_beat) begin
      results_checked++;
      if (expected_as_q.size() == 0) begin
        $display("%0t: result beat with nothing expected, as_number %0h", $time, as_number);
        error_count++;
      end else begin
        want = expected_as_q.pop_front();
        check_field("path_found", 32'(want.found), 32'(path_found));
        check_field("as_number", want.asn, as_number);
        check_field("path_index", 32'(want.idx), 32'(path_index));
        check_field("path_length", 32'(want.len), 32'(path_length));
        check_field("last", 32'(want.final_beat), 32'(last));
      end
    end
    if (byte_beat || result_beat) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, idle_cycles);
      $display("bgp_as_path_attribute_parser test failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold_active = 1'b1;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active = 1'b0;
      end else begin
        n = pick_gap();
        if (n > 0) begin
          result_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        result_stall <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] d, input logic f, input logic e, input logic w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid <= 1'b1;
    data_byte <= d;
    first_of_record <= f;
    end_of_record <= e;
    as_four_bytes <= w;
    do @(posedge clk); while (byte_stall);
  endtask

  function automatic logic [31:0] random_as();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_segment(input logic [7:0] kind, input int count, input bit wide);
    logic [31:0] v;
    value_bytes.push_back(kind);
    value_bytes.push_back(count[7:0]);
    repeat (count) begin
      v = random_as();
      if (wide) begin
        value_bytes.push_back(v[31:24]);
        value_bytes.push_back(v[23:16]);
      end
      value_bytes.push_back(v[15:8]);
      value_bytes.push_back(v[7:0]);
    end
  endfunction

  function automatic void add_filler(input int n);
    repeat (n) value_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void end_attribute(input logic [7:0] flags, input logic [7:0] kind);
    logic [15:0] n;
    n = 16'(value_bytes.size());
    block_bytes.push_back(flags);
    block_bytes.push_back(kind);
    if ((flags & ATTR_FLAG_EXTLEN) != 8'h00) block_bytes.push_back(n[15:8]);
    block_bytes.push_back(n[7:0]);
    foreach (value_bytes[i]) block_bytes.push_back(value_bytes[i]);
    value_bytes.delete();
  endfunction

  task automatic send_record(input bit wide, input int len_adjust, input int trailing,
                             input int cut);
    logic [15:0] total;
    logic w;
    int n;
    int i;
    total = 16'(block_bytes.size() + len_adjust);
    record_bytes.delete();
    record_bytes.push_back(total[15:8]);
    record_bytes.push_back(total[7:0]);
    foreach (block_bytes[j]) record_bytes.push_back(block_bytes[j]);
    repeat (trailing) record_bytes.push_back(8'($urandom_range(0, 255)));
    block_bytes.delete();
    n = record_bytes.size() - cut;
    if (n < 1) n = 1;
    for (i = 0; i < n; i++) begin
      w = (i == 0) ? wide : 1'($urandom_range(0, 1));
      send_byte(record_bytes[i], i == 0, i == n - 1, w);
    end
    records_sent++;
    record_bytes_sent += n;
  endtask

  task automatic test_outside_record();
    send_byte(8'hA5, 1'b0, 1'b0, 1'b1);
    send_byte(8'h5A, 1'b0, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b1, 1'b1);
  endtask

  task automatic test_block_edges();
    send_record(1'b0, 2, 2, 0);
    block_bytes.push_back(FLAGS_EXT);
    block_bytes.push_back(ATTR_AS_PATH);
    send_record(1'b1, 1, 1, 0);
    add_segment(SEG_AS_SEQUENCE, 2, 1'b0);
    end_attribute(FLAGS_SHORT, ATTR_AS_PATH);
    send_record(1'b0, -1, 0, 0);
    add_segment(SEG_AS_SEQUENCE, 3, 1'b1);
    end_attribute(FLAGS_SHORT, ATTR_AS_PATH);
    send_record(1'b1, 0, 3, 0);
  endtask

  task automatic test_segment_kinds();
    add_segment(SEG_AS_SEQUENCE, 2, 1'b0);
    add_segment(SEG_CONFED_SEQUENCE, 1, 1'b0);
    add_segment(SEG_CONFED_SET, 2, 1'b0);
    add_segment(SEG_AS_SET, 0, 1'b0);
    add_segment(SEG_AS_SET, 1, 1'b0);
    add_filler(1);
    end_attribute(FLAGS_EXT, ATTR_AS_PATH);
    send_record(1'b0, 0, 0, 0);
  endtask

  task automatic test_segment_errors();
    add_segment(SEG_AS_SET, 2, 1'b1);
    add_segment(SEG_UNKNOWN, 1, 1'b1);
    add_segment(SEG_AS_SEQUENCE, 1, 1'b1);
    end_attribute(FLAGS_SHORT, ATTR_AS_PATH);
    send_record(1'b1, 0, 0, 0);
    add_segment(SEG_AS_SEQUENCE, 1, 1'b0);
    value_bytes.push_back(SEG_AS_SEQUENCE);
    value_bytes.push_back(8'd200);
    add_filler(4);
    end_attribute(FLAGS_SHORT, ATTR_AS_PATH);
    send_record(1'b0, 0, 0, 0);
  endtask

  task automatic test_path_limits();
    add_segment(SEG_AS_SEQUENCE, 20, 1'b0);
    add_segment(SEG_AS_SET, 11, 1'b0);
    add_segment(SEG_AS_SEQUENCE, 1, 1'b0);
    end_attribute(FLAGS_EXT, ATTR_AS_PATH);
    send_record(1'b0, 0, 0, 0);
  endtask

  task automatic test_restarts();
    add_segment(SEG_AS_SEQUENCE, 2, 1'b0);
    end_attribute(FLAGS_SHORT, ATTR_AS_PATH);
    add_filler(1);
    end_attribute(FLAGS_SHORT, ATTR_ORIGIN);
    add_segment(SEG_AS_SEQUENCE, 1, 1'b0);
    end_attribute(FLAGS_SHORT, ATTR_AS_PATH);
    send_record(1'b0, 0, 0, 0);
    add_segment(SEG_AS_SEQUENCE, 1, 1'b0);
    add_segment(SEG_AS_SEQUENCE, 3, 1'b0);
    end_attribute(FLAGS_SHORT, ATTR_AS_PATH);
    send_record(1'b0, 0, 0, 3);
    send_byte(8'h00, 1'b1, 1'b0, 1'b0);
    send_byte(8'h09, 1'b0, 1'b0, 1'b0);
    send_byte(FLAGS_SHORT, 1'b0, 1'b0, 1'b1);
    add_segment(SEG_AS_SET, 2, 1'b1);
    end_attribute(FLAGS_SHORT, ATTR_AS_PATH);
    send_record(1'b1, 0, 0, 0);
  endtask

  task automatic test_receiver_holdoff();
    bit wide;
    byte_valid <= 1'b0;
    hold_req = 1'b1;
    while (!hold_active) @(posedge clk);
    repeat (4) begin
      wide = 1'($urandom_range(0, 1));
      add_segment(SEG_AS_SEQUENCE, $urandom_range(3, 6), wide);
      end_attribute(FLAGS_SHORT, ATTR_AS_PATH);
      send_record(wide, 0, 0, 0);
    end
  endtask

  task automatic test_random_records();
    int start;
    int r;
    bit wide;
    logic [7:0] kind;
    logic [7:0] attr;
    start = record_bytes_sent;
    while (record_bytes_sent - start < RANDOM_BYTES) begin
      if ($urandom_range(0, 9) == 0) no_idle = !no_idle;
      if ($urandom_range(0, 19) == 0) begin
        send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      end
      wide = 1'($urandom_range(0, 1));
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 9) < 6) begin
          repeat ($urandom_range(0, 3)) begin
            r = $urandom_range(0, 19);
            if (r < 14) kind = r[0] ? SEG_AS_SET : SEG_AS_SEQUENCE;
            else if (r < 17) kind = (r == 14) ? SEG_CONFED_SET : SEG_CONFED_SEQUENCE;
            else kind = 8'($urandom_range(0, 255));
            add_segment(kind, ($urandom_range(0, 7) == 0) ? $urandom_range(8, 14) :
                        $urandom_range(0, 5), wide);
          end
          if (value_bytes.size() >= 2 && $urandom_range(0, 7) == 0) begin
            value_bytes[1] = 8'($urandom_range(0, 255));
          end
          if ($urandom_range(0, 7) == 0) add_filler(1);
          attr = ATTR_AS_PATH;
        end else begin
          add_filler($urandom_range(0, 6));
          attr = 8'($urandom_range(0, 255));
        end
        end_attribute(8'($urandom_range(0, 255)), attr);
      end
      case ($urandom_range(0, 9))
        0: send_record(wide, int'($urandom_range(0, 6)) - 3, 0, 0);
        1: send_record(wide, 0, 0, $urandom_range(1, 5));
        2: send_record(wide, 0, $urandom_range(1, 3), 0);
        default: send_record(wide, 0, 0, 0);
      endcase
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_outside_record();
    test_block_edges();
    test_segment_kinds();
    test_segment_errors();
    test_path_limits();
    test_restarts();
    test_receiver_holdoff();
    test_random_records();
    byte_valid <= 1'b0;
    while (expected_as_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (expected_as_q.size() != 0) begin
      $display("%0t: %0d expected result beats never arrived", $time, expected_as_q.size());
      error_count++;
    end
    $display("Ran %0d records over %0d accepted byte beats and checked %0d result beats.",
             records_sent, bytes_accepted, results_checked);
    $display("Covered short and overrun blocks, odd segments, full paths, restarts, hold-off.");
    if (error_count == 0) begin
      $display("bgp_as_path_attribute_parser test passed");
    end else begin
      $display("bgp_as_path_attribute_parser test failed");
    end
    $finish;
  end

endmodule
